// ===== rtl/hrr_pkg.sv =====
// Shared types and register indexes for the haze radiance recovery core.
package hrr_pkg;

   typedef enum logic [2:0] {
      CSR_ATM_LIGHT_CH0  = 3'd0,
      CSR_ATM_LIGHT_CH1  = 3'd1,
      CSR_ATM_LIGHT_CH2  = 3'd2,
      CSR_HAZE_WEIGHT    = 3'd3,
      CSR_REMOVAL_AMOUNT = 3'd4,
      CSR_COLOR_MODE     = 3'd5,
      CSR_BOOST_ENABLE   = 3'd6,
      CSR_BOOST_GAIN     = 3'd7
   } csr_index_type;

   localparam int unsigned NUM_CH = 3;

endpackage

// ===== rtl/haze_radiance_recovery_core.sv =====
// Haze radiance recovery: per-pixel dehazing pipeline with CSR block.
//
// Usage:
//  - req_ channel takes one pixel transaction: transmission and three channel
//    samples, unsigned fixed point where all ones means 1.0.
//  - rsp_ channel returns one dehazed pixel transaction per request, in order.
//  - csr_ channel writes one register (index, data) per transaction; always
//    ready. Write registers only while the pipeline is empty.
// A request passes stages 1 and 2, stage 3 and the divider, then stages 4 to 8.
// The long pole is the radiance divider, one quotient bit per stage over
// SAMPLE_BITS + 4 stages, shared divisor for the three channels.
// Throughput: one pixel per clock while the receiver keeps rsp_tready high.
// Stall: when rsp_tvalid is high and rsp_tready low the whole pipeline holds,
// req_tready drops, and nothing is lost or repeated. An empty output register
// keeps the pipeline moving even while the receiver is stalled.
// Reset: synchronous, active high; clears all valid bits and returns the
// registers to their defaults (atm light 1.0, omega 0.9, amount 1.0, colour
// mode, boost off, boost gain 0.1).
module haze_radiance_recovery_core
   import hrr_pkg::*;
#(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   // fields low to high: transmission, pixel_ch0, pixel_ch1, pixel_ch2, pad
   input  logic [((4*SAMPLE_BITS+7)/8)*8-1:0]       req_tdata,
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   // fields low to high: clear_ch0, clear_ch1, clear_ch2, zero pad
   output logic [((3*SAMPLE_BITS+7)/8)*8-1:0]       rsp_tdata,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [2:0]                               csr_index,
   input  logic [SAMPLE_BITS-1:0]                   csr_data
);

   localparam int S   = SAMPLE_BITS;
   localparam int DQ  = SAMPLE_BITS + 4;            // quotient bits of the divider
   localparam int OW  = ((3*SAMPLE_BITS+7)/8)*8;
   localparam int ONE_INT  = (1 << SAMPLE_BITS) - 1;
   localparam int T0_INT   = (ONE_INT + 5) / 10;
   localparam int OMG_INT  = (9 * ONE_INT + 5) / 10;
   localparam int HALF_INT = ONE_INT / 2;
   localparam logic [S-1:0] ONE   = S'(ONE_INT);
   localparam logic [S-1:0] T0    = S'(T0_INT);
   localparam logic [S-1:0] OMG_R = S'(OMG_INT);

   // round(x / ONE), exact for x below 2^(2S+1) by folding twice
   function automatic logic [S+1:0] div_one(input logic [2*S+1:0] x);
      logic [2*S+1:0] y;
      logic [S+1:0]   q1;
      logic [S+2:0]   r1;
      logic [S:0]     r2;
      logic [S+1:0]   q2;
      y  = x + (2*S+2)'(HALF_INT);
      q1 = y[2*S+1:S];
      r1 = (S+3)'(y[S-1:0]) + (S+3)'(q1);
      r2 = (S+1)'(r1[S-1:0]) + (S+1)'(r1[S+2:S]);
      q2 = q1 + (S+2)'(r1[S+2:S]);
      if (r2 >= (S+1)'(ONE)) begin
         q2 = q2 + (S+2)'(1);
      end
      return q2;
   endfunction

   // ---------------- configuration registers ----------------
   logic [S-1:0] atm_ff [0:NUM_CH-1];
   logic [S-1:0] omega_ff, amount_ff, gain_ff;
   logic         color_ff, boost_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         atm_ff[0] <= ONE;
         atm_ff[1] <= ONE;
         atm_ff[2] <= ONE;
         omega_ff  <= OMG_R;
         amount_ff <= ONE;
         color_ff  <= 1'b1;
         boost_ff  <= 1'b0;
         gain_ff   <= T0;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_ATM_LIGHT_CH0:  atm_ff[0] <= csr_data;
            CSR_ATM_LIGHT_CH1:  atm_ff[1] <= csr_data;
            CSR_ATM_LIGHT_CH2:  atm_ff[2] <= csr_data;
            CSR_HAZE_WEIGHT:    omega_ff  <= csr_data;
            CSR_REMOVAL_AMOUNT: amount_ff <= csr_data;
            CSR_COLOR_MODE:     color_ff  <= csr_data[0];
            CSR_BOOST_ENABLE:   boost_ff  <= csr_data[0];
            CSR_BOOST_GAIN:     gain_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // whole pipeline advances unless the output register is full and stalled
   logic adv;
   logic out_vld_ff;
   assign adv        = !out_vld_ff || rsp_tready;
   assign req_tready = adv;

   // ---------------- stage 1: products and channel differences ----------------
   logic         s1_vld_ff;
   logic [S-1:0] s1_omt_ff;
   logic [2*S-1:0] s1_pw_ff, s1_pg_ff;
   logic [S-1:0] s1_v_ff [0:NUM_CH-1];
   logic [S-1:0] s1_d_ff [0:NUM_CH-1];
   logic         s1_ge_ff [0:NUM_CH-1];

   logic [S-1:0] in_t, omt_in, gain_eff;
   logic [S-1:0] in_v [0:NUM_CH-1];

   always_comb begin
      in_t     = req_tdata[S-1:0];
      in_v[0]  = req_tdata[2*S-1:S];
      in_v[1]  = req_tdata[3*S-1:2*S];
      in_v[2]  = req_tdata[4*S-1:3*S];
      omt_in   = ONE - in_t;
      gain_eff = (gain_ff == '0) ? T0 : gain_ff;   // zero gain acts as 0.1
   end

   always_ff @(posedge clock) begin
      if (reset) s1_vld_ff <= 1'b0;
      else if (adv) s1_vld_ff <= req_tvalid;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_omt_ff <= omt_in;
         s1_pw_ff  <= (2*S)'(omega_ff) * (2*S)'(omt_in);
         s1_pg_ff  <= (2*S)'(amount_ff) * (2*S)'(gain_eff);
         for (int c = 0; c < NUM_CH; c++) begin
            s1_v_ff[c]  <= in_v[c];
            s1_ge_ff[c] <= (in_v[c] >= atm_ff[c]);
            s1_d_ff[c]  <= (in_v[c] >= atm_ff[c]) ? in_v[c] - atm_ff[c] : atm_ff[c] - in_v[c];
         end
      end
   end

   // ---------------- stage 2: blended transmission, boost gain ----------------
   logic         s2_vld_ff;
   logic [S-1:0] s2_tb_ff, s2_g_ff, s2_omt_ff;
   logic [S-1:0] s2_v_ff [0:NUM_CH-1];
   logic [S-1:0] s2_d_ff [0:NUM_CH-1];
   logic         s2_ge_ff [0:NUM_CH-1];
   logic [S+1:0] pw_q, pg_q;

   always_comb begin
      pw_q = div_one((2*S+2)'(s1_pw_ff));
      pg_q = div_one((2*S+2)'(s1_pg_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) s2_vld_ff <= 1'b0;
      else if (adv) s2_vld_ff <= s1_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_tb_ff  <= ONE - pw_q[S-1:0];
         s2_g_ff   <= pg_q[S-1:0];
         s2_omt_ff <= s1_omt_ff;
         s2_v_ff   <= s1_v_ff;
         s2_d_ff   <= s1_d_ff;
         s2_ge_ff  <= s1_ge_ff;
      end
   end

   // ---------------- stage 3 + divider: radiance quotient ----------------
   // index 0 is loaded from stage 2; each later index retires one quotient bit
   logic           dv_vld_ff  [0:DQ];
   logic [S-1:0]   dv_tt_ff   [0:DQ];
   logic [S-1:0]   dv_tn_ff   [0:DQ];
   logic [2*S-1:0] dv_kraw_ff [0:DQ];
   logic [S-1:0]   dv_rem_ff  [0:DQ][0:NUM_CH-1];
   logic [DQ-1:0]  dv_work_ff [0:DQ][0:NUM_CH-1];
   logic [S-1:0]   dv_v_ff    [0:DQ][0:NUM_CH-1];
   logic           dv_ge_ff   [0:DQ][0:NUM_CH-1];

   logic [S-1:0]   tt_in, tn_in;
   logic [S:0]     tn_sum;
   logic [2*S-1:0] num_in [0:NUM_CH-1];

   always_comb begin
      tt_in  = (s2_tb_ff > T0) ? s2_tb_ff : T0;
      tn_sum = (S+1)'(s2_tb_ff) + (S+1)'(amount_ff);
      tn_in  = (tn_sum > (S+1)'(ONE)) ? ONE : tn_sum[S-1:0];
      for (int c = 0; c < NUM_CH; c++) begin
         // |v - a| * ONE + tt/2, the rounding bias of the quotient
         num_in[c] = ((2*S)'(s2_d_ff[c]) << S) - (2*S)'(s2_d_ff[c])
                   + (2*S)'(tt_in >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) dv_vld_ff[0] <= 1'b0;
      else if (adv) dv_vld_ff[0] <= s2_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_tt_ff[0]   <= tt_in;
         dv_tn_ff[0]   <= tn_in;
         dv_kraw_ff[0] <= (2*S)'(s2_g_ff) * (2*S)'(s2_omt_ff);
         for (int c = 0; c < NUM_CH; c++) begin
            dv_rem_ff[0][c]  <= S'(num_in[c][2*S-1:DQ]);
            dv_work_ff[0][c] <= num_in[c][DQ-1:0];
            dv_v_ff[0][c]    <= s2_v_ff[c];
            dv_ge_ff[0][c]   <= s2_ge_ff[c];
         end
      end
   end

   for (genvar j = 0; j < DQ; j++) begin : g_div
      logic [S:0]    trial [0:NUM_CH-1];
      logic          qbit  [0:NUM_CH-1];
      logic [S-1:0]  rem_in  [0:NUM_CH-1];
      logic [DQ-1:0] work_in [0:NUM_CH-1];

      always_comb begin
         for (int c = 0; c < NUM_CH; c++) begin
            trial[c] = {dv_rem_ff[j][c], dv_work_ff[j][c][DQ-1]};
            qbit[c]  = (trial[c] >= (S+1)'(dv_tt_ff[j]));
            rem_in[c] = qbit[c] ? S'(trial[c] - (S+1)'(dv_tt_ff[j])) : trial[c][S-1:0];
            work_in[c] = {dv_work_ff[j][c][DQ-2:0], qbit[c]};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) dv_vld_ff[j+1] <= 1'b0;
         else if (adv) dv_vld_ff[j+1] <= dv_vld_ff[j];
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dv_tt_ff[j+1]   <= dv_tt_ff[j];
            dv_tn_ff[j+1]   <= dv_tn_ff[j];
            dv_kraw_ff[j+1] <= dv_kraw_ff[j];
            dv_rem_ff[j+1]  <= rem_in;
            dv_work_ff[j+1] <= work_in;
            dv_v_ff[j+1]    <= dv_v_ff[j];
            dv_ge_ff[j+1]   <= dv_ge_ff[j];
         end
      end
   end

   // ---------------- stage 4: radiance around atm light, boost factor ----------------
   logic         s4_vld_ff;
   logic [S-1:0] s4_tn_ff, s4_k_ff;
   logic [S-1:0] s4_rad_ff [0:NUM_CH-1];
   logic [S-1:0] s4_v_ff   [0:NUM_CH-1];
   logic [S-1:0] rad_in    [0:NUM_CH-1];
   logic [DQ:0]  rad_sum   [0:NUM_CH-1];
   logic [DQ-1:0] quo      [0:NUM_CH-1];
   logic [S+1:0] k_q;

   always_comb begin
      k_q = div_one((2*S+2)'(dv_kraw_ff[DQ]));
      for (int c = 0; c < NUM_CH; c++) begin
         quo[c]     = dv_work_ff[DQ][c];
         rad_sum[c] = (DQ+1)'(atm_ff[c]) + (DQ+1)'(quo[c]);
         if (dv_ge_ff[DQ][c]) begin
            rad_in[c] = (rad_sum[c] > (DQ+1)'(ONE)) ? ONE : rad_sum[c][S-1:0];
         end else begin
            rad_in[c] = (quo[c] >= DQ'(atm_ff[c])) ? '0 : atm_ff[c] - quo[c][S-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) s4_vld_ff <= 1'b0;
      else if (adv) s4_vld_ff <= dv_vld_ff[DQ];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_tn_ff  <= dv_tn_ff[DQ];
         s4_k_ff   <= k_q[S-1:0];
         s4_rad_ff <= rad_in;
         s4_v_ff   <= dv_v_ff[DQ];
      end
   end

   // ---------------- stage 5: re-blend products ----------------
   logic           s5_vld_ff;
   logic [S-1:0]   s5_k_ff;
   logic [2*S-1:0] s5_m1_ff [0:NUM_CH-1];
   logic [2*S-1:0] s5_m2_ff [0:NUM_CH-1];
   logic [S-1:0]   s5_v_ff  [0:NUM_CH-1];

   always_ff @(posedge clock) begin
      if (reset) s5_vld_ff <= 1'b0;
      else if (adv) s5_vld_ff <= s4_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s5_k_ff <= s4_k_ff;
         s5_v_ff <= s4_v_ff;
         for (int c = 0; c < NUM_CH; c++) begin
            s5_m1_ff[c] <= (2*S)'(s4_rad_ff[c]) * (2*S)'(s4_tn_ff);
            s5_m2_ff[c] <= (2*S)'(atm_ff[c]) * (2*S)'(ONE - s4_tn_ff);
         end
      end
   end

   // ---------------- stage 6: re-blend rounding ----------------
   logic         s6_vld_ff;
   logic [S-1:0] s6_k_ff;
   logic [S-1:0] s6_b_ff [0:NUM_CH-1];
   logic [S-1:0] s6_v_ff [0:NUM_CH-1];
   logic [S+1:0] blend_q [0:NUM_CH-1];

   always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
         blend_q[c] = div_one((2*S+2)'(s5_m1_ff[c]) + (2*S+2)'(s5_m2_ff[c]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) s6_vld_ff <= 1'b0;
      else if (adv) s6_vld_ff <= s5_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s6_k_ff <= s5_k_ff;
         s6_v_ff <= s5_v_ff;
         for (int c = 0; c < NUM_CH; c++) begin
            s6_b_ff[c] <= (blend_q[c] > (S+2)'(ONE)) ? ONE : blend_q[c][S-1:0];
         end
      end
   end

   // ---------------- stage 7: boost product ----------------
   logic           s7_vld_ff;
   logic [2*S:0]   s7_bp_ff [0:NUM_CH-1];
   logic [S-1:0]   s7_b_ff  [0:NUM_CH-1];
   logic [S-1:0]   s7_v_ff  [0:NUM_CH-1];

   always_ff @(posedge clock) begin
      if (reset) s7_vld_ff <= 1'b0;
      else if (adv) s7_vld_ff <= s6_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s7_b_ff <= s6_b_ff;
         s7_v_ff <= s6_v_ff;
         for (int c = 0; c < NUM_CH; c++) begin
            s7_bp_ff[c] <= (2*S+1)'(s6_b_ff[c])
                         * ((2*S+1)'(ONE) + (2*S+1)'(s6_k_ff));
         end
      end
   end

   // ---------------- stage 8: output register ----------------
   logic [S-1:0] out_ff  [0:NUM_CH-1];
   logic [S-1:0] out_in  [0:NUM_CH-1];
   logic [S+1:0] boost_q [0:NUM_CH-1];

   always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
         boost_q[c] = div_one((2*S+2)'(s7_bp_ff[c]));
         if (amount_ff == '0) begin
            out_in[c] = s7_v_ff[c];                     // zero amount: pass through
         end else if (boost_ff) begin
            out_in[c] = (boost_q[c] > (S+2)'(ONE)) ? ONE : boost_q[c][S-1:0];
         end else begin
            out_in[c] = s7_b_ff[c];
         end
         if (!color_ff && c != 0) begin
            out_in[c] = '0;                             // grey mode
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) out_vld_ff <= 1'b0;
      else if (adv) out_vld_ff <= s7_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff <= out_in;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = OW'({out_ff[2], out_ff[1], out_ff[0]});

endmodule
